// ----- hdl/bbl_pkg.sv -----
// Shared types and constants of the monochrome bitmap blit unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbl_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X        = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y        = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd2;
   localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd3;
   localparam logic [2:0] REG_SET_BIT_COLOR   = 3'd4;
   localparam logic [2:0] REG_CLEAR_BIT_COLOR = 3'd5;

   // Reset values of the configuration registers
   localparam logic [7:0]  RESET_IMAGE_WIDTH     = 8'd8;
   localparam logic [7:0]  RESET_IMAGE_HEIGHT    = 8'd8;
   localparam logic [15:0] RESET_CLEAR_BIT_COLOR = 16'hFFFF;

   // Pixels in one bitmap byte
   localparam logic [3:0] PIXELS_PER_BYTE = 4'd8;

   // Byte descriptor queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic [7:0]  origin_x;
      logic [7:0]  origin_y;
      logic [7:0]  image_width;
      logic [7:0]  image_height;
      logic [15:0] set_bit_color;
      logic [15:0] clear_bit_color;
   } cfg_type;

   // One bitmap byte that produces at least one pixel
   typedef struct packed {
      logic [7:0] data;       // bitmap bits, leftmost pixel in bit 7
      logic [3:0] count;      // pixels to draw, 1 to 8
      logic [7:0] first_col;  // image column of the first pixel
      logic [7:0] row;        // image row
      logic       img_end;    // byte closes the image
   } desc_type;

endpackage

// ----- hdl/bbl_front.sv -----
// Front end of the blit unit: configuration registers, row/byte tracking,
// classification of each bitmap byte into a pixel-run descriptor. Uses bbl_pkg.
`timescale 1ns / 1ps

module bbl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_bitmap_byte,
   input  logic               q_full,
   output logic               q_push,
   output bbl_pkg::desc_type  q_desc,
   output bbl_pkg::cfg_type   cfg
);
   import bbl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [7:0] row_ff, row_in;
   logic [4:0] byte_ff, byte_in;
   logic       done_ff, done_in;

   logic       csr_write;
   logic       accept;
   logic       stopped;
   logic [7:0] wm1;
   logic [5:0] bpr;
   logic [7:0] first_col;
   logic [7:0] remain;
   logic [3:0] count;
   logic       row_end;
   logic       img_end;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign cfg       = cfg_ff;

   // Byte classification
   always_comb begin
      wm1       = cfg_ff.image_width - 8'd1;
      bpr       = (cfg_ff.image_width == 8'd0) ? 6'd1 : ({1'b0, wm1[7:3]} + 6'd1);
      first_col = {byte_ff, 3'b000};
      remain    = cfg_ff.image_width - first_col;
      if (cfg_ff.image_width > first_col) begin
         count = (remain > {4'd0, PIXELS_PER_BYTE}) ? PIXELS_PER_BYTE : remain[3:0];
      end else begin
         count = 4'd0;
      end
      row_end = ({1'b0, byte_ff} + 6'd1) >= bpr;
      img_end = row_end && (({1'b0, row_ff} + 9'd1) >= {1'b0, cfg_ff.image_height});
      stopped = done_ff || (row_ff >= cfg_ff.image_height);
   end

   assign q_push           = accept && !stopped && (count != 4'd0);
   assign q_desc.data      = req_bitmap_byte;
   assign q_desc.count     = count;
   assign q_desc.first_col = first_col;
   assign q_desc.row       = row_ff;
   assign q_desc.img_end   = img_end;

   // Configuration writes; any write restarts the image
   always_comb begin
      cfg_in  = cfg_ff;
      row_in  = row_ff;
      byte_in = byte_ff;
      done_in = done_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X:        cfg_in.origin_x        = csr_write_data[7:0];
            REG_ORIGIN_Y:        cfg_in.origin_y        = csr_write_data[7:0];
            REG_IMAGE_WIDTH:     cfg_in.image_width     = csr_write_data[7:0];
            REG_IMAGE_HEIGHT:    cfg_in.image_height    = csr_write_data[7:0];
            REG_SET_BIT_COLOR:   cfg_in.set_bit_color   = csr_write_data;
            REG_CLEAR_BIT_COLOR: cfg_in.clear_bit_color = csr_write_data;
            default: begin
            end
         endcase
         row_in  = 8'd0;
         byte_in = 5'd0;
         done_in = 1'b0;
      end else if (accept) begin
         if (stopped) begin
            done_in = 1'b1;
         end else if (row_end) begin
            byte_in = 5'd0;
            row_in  = row_ff + 8'd1;
            done_in = img_end;
         end else begin
            byte_in = byte_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x        <= 8'd0;
         cfg_ff.origin_y        <= 8'd0;
         cfg_ff.image_width     <= RESET_IMAGE_WIDTH;
         cfg_ff.image_height    <= RESET_IMAGE_HEIGHT;
         cfg_ff.set_bit_color   <= 16'd0;
         cfg_ff.clear_bit_color <= RESET_CLEAR_BIT_COLOR;
         row_ff                 <= 8'd0;
         byte_ff                <= 5'd0;
         done_ff                <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         row_ff  <= row_in;
         byte_ff <= byte_in;
         done_ff <= done_in;
      end
   end

endmodule

// ----- hdl/bbl_queue.sv -----
// Short descriptor queue decoupling the front end from the pixel back end.
// Uses bbl_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module bbl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bbl_pkg::desc_type  push_desc,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output bbl_pkg::desc_type  head
);
   import bbl_pkg::*;

   desc_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;

   localparam logic [QUEUE_PTR_BITS-1:0] LastPtr = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] FullCnt = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   assign full  = (cnt_ff == FullCnt);
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("descriptor queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("descriptor queue read while empty");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= FullCnt)
      else $error("descriptor queue occupancy out of range");

endmodule

// ----- hdl/bbl_back.sv -----
// Back end of the blit unit: walks each descriptor one pixel per cycle while the
// output is not stalled; forms address, color word and flags into the output register. Uses bbl_pkg.
`timescale 1ns / 1ps

module bbl_back #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  bbl_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  bbl_pkg::desc_type  head,
   output logic               head_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [14:0]        rsp_pixel_address,
   output logic [15:0]        rsp_pixel_value,
   output logic               rsp_off_screen,
   output logic               rsp_last_of_byte,
   output logic               rsp_last_of_image
);
   import bbl_pkg::*;

   localparam logic [10:0] ScreenW = 11'(SCREEN_WIDTH);
   localparam logic [10:0] ScreenH = 11'(SCREEN_HEIGHT);

   logic [2:0]  pix_ff, pix_in;
   logic        out_valid_ff, out_valid_in;
   logic [14:0] addr_ff;
   logic [15:0] value_ff;
   logic        off_ff, lastb_ff, lasti_ff;

   logic        advance;
   logic        lastb;
   logic [9:0]  px;
   logic [9:0]  py;
   logic        off;
   logic [20:0] lin;
   logic        bit_set;
   logic [15:0] color;

   assign advance  = head_valid && (!out_valid_ff || rsp_pop);
   assign lastb    = ({1'b0, pix_ff} + 4'd1) == head.count;
   assign head_pop = advance && lastb;

   // Pixel position, address and color
   always_comb begin
      px      = {2'b00, cfg.origin_x} + {2'b00, head.first_col} + {7'd0, pix_ff};
      py      = {2'b00, cfg.origin_y} + {2'b00, head.row};
      off     = ({1'b0, px} >= ScreenW) || ({1'b0, py} >= ScreenH);
      lin     = (21'(py) * 21'(ScreenW)) + 21'(px);
      bit_set = head.data[3'd7 - pix_ff];
      color   = bit_set ? cfg.set_bit_color : cfg.clear_bit_color;
   end

   // Pixel index and output register control
   always_comb begin
      pix_in       = pix_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         pix_in       = lastb ? 3'd0 : pix_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pix_ff       <= pix_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff  <= off ? 15'd0 : lin[14:0];
         value_ff <= ~{color[7:0], color[15:8]};
         off_ff   <= off;
         lastb_ff <= lastb;
         lasti_ff <= lastb && head.img_end;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_off_screen    = off_ff;
   assign rsp_last_of_byte  = lastb_ff;
   assign rsp_last_of_image = lasti_ff;

   // Checks
   a_pix_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, pix_ff} < head.count))
      else $error("pixel index beyond descriptor run");
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (pix_ff == 3'd0))
      else $error("pixel index not cleared after last pixel of a byte");

endmodule

// ----- hdl/monochrome_bitmap_blit_unit.sv -----
// Top level of the monochrome bitmap blit unit.
// Instantiates bbl_front, bbl_queue and bbl_back; uses bbl_pkg.
//
// Usage:
//  - Configuration: csr_valid/csr_ready with csr_index and csr_write_data.
//    csr_ready is always high. Indexes 0..5 are origin_x, origin_y,
//    image_width, image_height, set_bit_color, clear_bit_color. Any write,
//    also to an unused index, restarts the image at row 0, byte 0.
//  - Input: one bitmap byte per word on req_bitmap_byte, taken when req_push
//    is high and req_full is low. Rows are padded to whole bytes, MSB first.
//  - Output: framebuffer writes, oldest on rsp_* while rsp_empty is low,
//    taken when rsp_pop is high. off_screen words carry address 0 and are to
//    be dropped; bytes after the image produce no words.
//  - Throughput: one pixel word per cycle while rsp_pop is high and the
//    queue is not empty. The back end pixel walk sets this rate; the
//    4-entry descriptor queue absorbs input bursts.
//  - Path: with the back end idle, an accepted byte is written into the
//    descriptor queue, and its first word then into the output register.
//  - A stalled receiver holds the output register; the back end stops, then
//    the queue fills, then req_full rises. Nothing is dropped.
//  - Reset (synchronous, active high) empties the queue and output, restores
//    the default configuration and restarts the image.
`timescale 1ns / 1ps

module monochrome_bitmap_blit_unit #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_bitmap_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [14:0] rsp_pixel_address,
   output logic [15:0] rsp_pixel_value,
   output logic        rsp_off_screen,
   output logic        rsp_last_of_byte,
   output logic        rsp_last_of_image
);
   import bbl_pkg::*;

   cfg_type  cfg;
   desc_type push_desc;
   desc_type head;
   logic     q_push;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;

   bbl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_bitmap_byte (req_bitmap_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_desc          (push_desc),
      .cfg             (cfg)
   );

   bbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head)
   );

   bbl_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (!q_empty),
      .head              (head),
      .head_pop          (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_off_screen    (rsp_off_screen),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the monochrome bitmap blit unit.
// Depends on bbl_pkg and monochrome_bitmap_blit_unit;
// drives every port and checks each pixel word.
`timescale 1ns / 1ps

module testbench;
   import bbl_pkg::*;

   localparam int SCREEN_W     = 256;
   localparam int SCREEN_H     = 128;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 85;
   localparam int LONG_STALL   = 300;
   localparam int MAX_REPORTS  = 10;

   // Indexes past the register list: no register, but the image restarts
   localparam logic [2:0] REG_UNUSED_6 = 3'd6;
   localparam logic [2:0] REG_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [14:0] address;
      logic [15:0] value;
      logic        off_screen;
      logic        last_of_byte;
      logic        last_of_image;
   } pixel_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_bitmap_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [14:0] rsp_pixel_address;
   logic [15:0] rsp_pixel_value;
   logic        rsp_off_screen;
   logic        rsp_last_of_byte;
   logic        rsp_last_of_image;

   // Predictor copy of configuration and image walk
   cfg_type     cfg;
   int          row_pos;
   int          byte_pos;
   bit          img_finished;

   pixel_word_type pending_pixels[$];
   int          mismatch_count = 0;
   int          image_items = 0;
   bit          steady_flow = 1'b0;
   int          stall_request = 0;

   monochrome_bitmap_blit_unit #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_bitmap_byte  (req_bitmap_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_address(rsp_pixel_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_off_screen   (rsp_off_screen),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_last_of_image(rsp_last_of_image)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] fb_word(input logic [15:0] color);
      return ~{color[7:0], color[15:8]};
   endfunction

   function automatic void restart_image();
      row_pos = 0;
      byte_pos = 0;
      img_finished = 1'b0;
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         REG_ORIGIN_X:        cfg.origin_x = data[7:0];
         REG_ORIGIN_Y:        cfg.origin_y = data[7:0];
         REG_IMAGE_WIDTH:     cfg.image_width = data[7:0];
         REG_IMAGE_HEIGHT:    cfg.image_height = data[7:0];
         REG_SET_BIT_COLOR:   cfg.set_bit_color = data;
         REG_CLEAR_BIT_COLOR: cfg.clear_bit_color = data;
         default: ;
      endcase
      restart_image();
   endfunction

   // Queue the pixel words one bitmap byte yields; returns 0 for bytes past the image
   function automatic bit expand_byte(input logic [7:0] b);
      int          width;
      int          height;
      int          per_row;
      int          first_col;
      int          npix;
      int          px;
      int          py;
      bit          row_end;
      bit          img_end;
      bit          off;
      pixel_word_type w;
      width = int'(cfg.image_width);
      height = int'(cfg.image_height);
      if (img_finished || row_pos >= height) begin
         img_finished = 1'b1;
         return 1'b0;
      end
      per_row = (width == 0) ? 1 : ((width - 1) >> 3) + 1;
      first_col = byte_pos * 8;
      if (width > first_col)
         npix = (width - first_col > 8) ? 8 : width - first_col;
      else
         npix = 0;
      row_end = (byte_pos + 1) >= per_row;
      img_end = row_end && (row_pos + 1) >= height;
      py = int'(cfg.origin_y) + row_pos;
      for (int j = 0; j < npix; j++) begin
         px = int'(cfg.origin_x) + first_col + j;
         off = (px >= SCREEN_W) || (py >= SCREEN_H);
         w.address = off ? '0 : 15'(py * SCREEN_W + px);
         w.value = fb_word(b[7 - j] ? cfg.set_bit_color : cfg.clear_bit_color);
         w.off_screen = off;
         w.last_of_byte = (j + 1 == npix);
         w.last_of_image = (j + 1 == npix) && img_end;
         pending_pixels.push_back(w);
      end
      if (row_end) begin
         byte_pos = 0;
         row_pos++;
         if (img_end)
            img_finished = 1'b1;
      end else begin
         byte_pos++;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Mostly back to back, sometimes a short gap, now and then a long pause
   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one bitmap byte; push stays high on return so a back-to-back word can follow
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_bitmap_byte <= b;
      @(posedge clock);
      while (req_full !== 1'b0)
         @(posedge clock);
      if (expand_byte(b))
         image_items++;
   endtask

   // Register write; valid stays high when more writes follow
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      apply_reg(idx, data);
      if (last)
         csr_valid <= 1'b0;
   endtask

   // Write all six registers in random order, upper bits of byte registers as noise
   task automatic load_setup(input cfg_type s, input bit add_unused);
      int          order[7];
      int          n;
      int          k;
      int          t;
      logic [2:0]  idx;
      logic [15:0] data;
      n = add_unused ? 7 : 6;
      for (int i = 0; i < 6; i++)
         order[i] = i;
      order[6] = $urandom_range(0, 1) ? int'(REG_UNUSED_6) : int'(REG_UNUSED_7);
      for (int i = n - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = order[i];
         order[i] = order[k];
         order[k] = t;
      end
      for (int i = 0; i < n; i++) begin
         idx = 3'(order[i]);
         case (idx)
            REG_ORIGIN_X:        data = {8'($urandom), s.origin_x};
            REG_ORIGIN_Y:        data = {8'($urandom), s.origin_y};
            REG_IMAGE_WIDTH:     data = {8'($urandom), s.image_width};
            REG_IMAGE_HEIGHT:    data = {8'($urandom), s.image_height};
            REG_SET_BIT_COLOR:   data = s.set_bit_color;
            REG_CLEAR_BIT_COLOR: data = s.clear_bit_color;
            default:             data = 16'($urandom);
         endcase
         write_reg(idx, data, i == n - 1);
      end
   endtask

   // Stop offering, let every expected word drain, then give the pipe time to settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_pixel();
      pixel_word_type got;
      pixel_word_type exp_w;
      got = '{rsp_pixel_address, rsp_pixel_value, rsp_off_screen,
              rsp_last_of_byte, rsp_last_of_image};
      if (pending_pixels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected pixel word addr=%h value=%h off=%b lb=%b li=%b",
                     $realtime, got.address, got.value, got.off_screen,
                     got.last_of_byte, got.last_of_image);
         return;
      end
      exp_w = pending_pixels.pop_front();
      if (got.address !== exp_w.address || got.value !== exp_w.value ||
          got.off_screen !== exp_w.off_screen || got.last_of_byte !== exp_w.last_of_byte ||
          got.last_of_image !== exp_w.last_of_image) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: pixel mismatch exp addr=%h value=%h off=%b lb=%b li=%b, ",
                      "got addr=%h value=%h off=%b lb=%b li=%b"},
                     $realtime, exp_w.address, exp_w.value, exp_w.off_screen,
                     exp_w.last_of_byte, exp_w.last_of_image, got.address, got.value,
                     got.off_screen, got.last_of_byte, got.last_of_image);
      end
   endtask

   // Receiver: random pop gaps, plus a long hold-off on request
   initial begin : pixel_sink
      int   gap_left;
      int   stall_left;
      logic next_pop;
      gap_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && rsp_empty === 1'b0) begin
            check_pixel();
            gap_left = pick_gap();
         end
         if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            next_pop = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            next_pop = 1'b0;
         end else begin
            next_pop = 1'b1;
         end
         rsp_pop <= next_pop;
      end
   end

   // Watchdog: ends the run after too many cycles with no word moving anywhere
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("monochrome_bitmap_blit_unit test failed");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // Reset configuration: 8x8 at the origin, then one byte past the image
   task automatic test_default_image();
      logic [7:0] bytes[9] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                               8'hC3};
      foreach (bytes[i])
         send_byte(bytes[i]);
      wait_idle();
   endtask

   // Partial last byte, columns past the right edge, rows past the bottom
   task automatic test_edges_and_partial();
      cfg_type    s;
      logic [7:0] bytes[7] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h81, 8'h7E, 8'h3C};
      s = '{8'd250, 8'd126, 8'd13, 8'd3, 16'h1234, 16'hABCD};
      load_setup(s, 1'b0);
      foreach (bytes[i])
         send_byte(bytes[i]);
      wait_idle();
   endtask

   // Zero width: each byte is a row with no pixels; zero height: nothing at all
   task automatic test_zero_sizes();
      cfg_type s;
      s = '{8'd0, 8'd0, 8'd0, 8'd2, 16'hFFFF, 16'h0000};
      load_setup(s, 1'b0);
      repeat (3) send_byte(8'($urandom));
      wait_idle();
      s.image_width = 8'd8;
      s.image_height = 8'd0;
      load_setup(s, 1'b0);
      repeat (2) send_byte(8'($urandom));
      wait_idle();
   endtask

   // A write to an index past the list still restarts the image
   task automatic test_restart();
      cfg_type s;
      s = '{8'd0, 8'd0, 8'd8, 8'd2, 16'h00F0, 16'h0F00};
      load_setup(s, 1'b0);
      send_byte(8'hE7);
      wait_idle();
      write_reg(REG_UNUSED_6, 16'hFFFF, 1'b1);
      send_byte(8'h18);
      send_byte(8'h99);
      wait_idle();
      write_reg(REG_UNUSED_7, 16'h0000, 1'b1);
      send_byte(8'h66);
      wait_idle();
   endtask

   // Receiver holds off while the sender keeps pushing, so the input stalls
   task automatic test_output_backpressure();
      cfg_type s;
      s = '{8'd100, 8'd50, 8'd16, 8'd4, 16'($urandom), 16'($urandom)};
      load_setup(s, 1'b0);
      steady_flow = 1'b1;
      stall_request = LONG_STALL;
      @(posedge clock);
      repeat (8) send_byte(8'($urandom));
      wait_idle();
      steady_flow = 1'b0;
   endtask

   function automatic logic [7:0] pick_origin(input int edge_pos);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return 8'd0;
      if (r < 4)
         return 8'd255;
      if (r < 6)
         return 8'(edge_pos + $urandom_range(0, 7));
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_color();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_bitmap();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   // Random images: mostly complete, some cut short, some with trailing bytes
   task automatic test_random_images();
      cfg_type s;
      int      start_items;
      int      mode;
      int      per_row;
      int      nbytes;
      int      r;
      start_items = image_items;
      while (image_items - start_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 11);
         s.origin_x = pick_origin(SCREEN_W - 12);
         s.origin_y = pick_origin(SCREEN_H - 4);
         s.set_bit_color = pick_color();
         s.clear_bit_color = pick_color();
         case (mode)
            0: begin
               s.image_width = 8'd255;
               s.image_height = 8'd1;
            end
            1: begin
               s.image_width = 8'($urandom_range(1, 8));
               s.image_height = 8'd255;
            end
            2: begin
               s.image_width = 8'd0;
               s.image_height = 8'($urandom_range(1, 4));
            end
            3: begin
               s.image_width = 8'($urandom_range(1, 16));
               s.image_height = 8'd0;
            end
            default: begin
               s.image_width = 8'($urandom_range(1, 24));
               s.image_height = 8'($urandom_range(1, 4));
            end
         endcase
         steady_flow = ($urandom_range(0, 3) == 0);
         load_setup(s, $urandom_range(0, 4) == 0);
         per_row = (s.image_width == 0) ? 1 : ((int'(s.image_width) - 1) >> 3) + 1;
         nbytes = per_row * int'(s.image_height);
         if (mode == 1)
            nbytes = $urandom_range(6, 12);
         else if (mode == 3)
            nbytes = 2;
         r = $urandom_range(0, 99);
         if (r < 30)
            nbytes += $urandom_range(1, 2);
         else if (r < 45 && nbytes > 1)
            nbytes -= $urandom_range(1, nbytes - 1);
         repeat (nbytes) send_byte(pick_bitmap());
         wait_idle();
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      cfg = '{8'd0, 8'd0, RESET_IMAGE_WIDTH, RESET_IMAGE_HEIGHT, 16'h0000,
              RESET_CLEAR_BIT_COLOR};
      restart_image();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_image();
      test_edges_and_partial();
      test_zero_sizes();
      test_restart();
      test_output_backpressure();
      test_random_images();
      wait_idle();
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("monochrome_bitmap_blit_unit test passed");
      else
         $display("monochrome_bitmap_blit_unit test failed");
      $finish;
   end

endmodule
